@@ hdl/odt_pkg.sv @@
package odt_pkg;

    localparam int MAX_IMAGES_DEF        = 16;
    localparam int ENTRY_STORE_DEPTH_DEF = 1024;
    localparam int HANDLE_BITS_DEF       = 16;

    typedef enum logic [2:0] {
        OP_BEGIN      = 3'd0,
        OP_ADD        = 3'd1,
        OP_ACTIVATE   = 3'd2,
        OP_INVALIDATE = 3'd3,
        OP_RESOLVE    = 3'd4,
        OP_QUERY      = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_ALREADY     = 4'd1,
        ST_EMPTY       = 4'd2,
        ST_OUTSIDE     = 4'd3,
        ST_BAD_MODE    = 4'd4,
        ST_MISALIGNED  = 4'd5,
        ST_NULL_HANDLE = 4'd6,
        ST_UNSORTED    = 4'd7,
        ST_NOT_REG     = 4'd8,
        ST_NO_PENDING  = 4'd9,
        ST_FULL        = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_WAIT,
        S_CHECK,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat and apply non-search ops
        logic scan;      // step the image scan
        logic rd;        // issue entry-store read at mid
        logic step;      // narrow search window from read data
        logic fin_rd;    // issue read at lo
        logic finish;    // compare final entry
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_resolve;
        logic scan_last;
        logic owner_hit;
        logic search_done;
    } stat_t;

endpackage

@@ hdl/odt_datapath.sv @@
module odt_datapath
    import odt_pkg::*;
#(
    parameter int MAX_IMAGES        = MAX_IMAGES_DEF,
    parameter int ENTRY_STORE_DEPTH = ENTRY_STORE_DEPTH_DEF,
    parameter int HANDLE_BITS       = HANDLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  opcode,
    input  logic [3:0]  image_id,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    input  logic [31:0] entry_pc,
    input  logic [7:0]  entry_mode,
    input  logic [15:0] entry_handle,
    input  logic        entry_last,
    output logic [3:0]  status,
    output logic        hit,
    output logic [15:0] hit_handle,
    output logic        owner_found,
    output logic [3:0]  owner_id,
    output logic [4:0]  removed_count,
    output logic        is_active_flag
);

    localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
    localparam int AW = $clog2(ENTRY_STORE_DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = $clog2(MAX_IMAGES + 1);
    localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    // image table and masks
    logic [MAX_IMAGES-1:0] reg_mask_reg, act_mask_reg;
    logic [31:0] img_start [MAX_IMAGES];
    logic [31:0] img_end   [MAX_IMAGES];
    logic [AW-1:0] img_base [MAX_IMAGES];
    logic [CW-1:0] img_count [MAX_IMAGES];

    // entry store
    logic [32:0] key_mem [ENTRY_STORE_DEPTH];
    logic [HANDLE_BITS-1:0] hnd_mem [ENTRY_STORE_DEPTH];
    logic [32:0] rd_key_reg;
    logic [HANDLE_BITS-1:0] rd_hnd_reg;

    logic [CW-1:0] fill_reg, pcount_reg;
    logic pvalid_reg;
    logic [IW-1:0] pid_reg;
    logic [31:0] pstart_reg, pend_reg;
    logic [32:0] prev_key_reg;

    // captured resolve item and search state
    logic [31:0] pc_reg;
    logic [32:0] target_reg;
    logic [IW-1:0] scan_idx_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [AW-1:0] base_reg;
    logic [CW-1:0] cnt_reg;
    logic is_res_reg;

    logic [3:0] status_reg;
    logic hit_reg, owner_found_reg, act_flag_reg;
    logic [15:0] hit_handle_reg;
    logic [3:0] owner_id_reg;
    logic [4:0] removed_reg;

    logic id_ok;
    logic [IW-1:0] idx;
    logic [31:0] pc_m;
    logic [32:0] in_key;
    logic [CW-1:0] slot;
    logic [HANDLE_BITS-1:0] hnd_m;
    logic [3:0] add_st;
    logic [CW-1:0] mid;
    logic [MAX_IMAGES-1:0] ovl_act, ovl_inv;
    logic [SW-1:0] inv_n;
    logic [31:0] act_s, act_e;
    logic owner_hit_c;

    assign id_ok  = ({28'd0, image_id} < 32'(MAX_IMAGES));
    assign idx    = IW'(image_id);
    assign pc_m   = entry_pc;
    assign in_key = {pc_m, entry_mode[0]};
    assign slot   = fill_reg + pcount_reg;
    assign hnd_m  = HANDLE_BITS'(entry_handle);
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign act_s  = img_start[idx];
    assign act_e  = img_end[idx];

    // add-entry checks, in priority order
    always_comb
    begin
        if (!pvalid_reg)
            add_st = ST_NO_PENDING;
        else if (pc_m < pstart_reg || pc_m >= pend_reg)
            add_st = ST_OUTSIDE;
        else if (entry_mode > 8'd1)
            add_st = ST_BAD_MODE;
        else if (pc_m[0] || (entry_mode == 8'd0 && pc_m[1]))
            add_st = ST_MISALIGNED;
        else if (hnd_m == '0)
            add_st = ST_NULL_HANDLE;
        else if (pcount_reg != '0 && in_key <= prev_key_reg)
            add_st = ST_UNSORTED;
        else if ({1'b0, slot} >= (CW+1)'(ENTRY_STORE_DEPTH))
            add_st = ST_FULL;
        else
            add_st = ST_OK;
    end

    // overlap vectors for activate and invalidate
    always_comb
    begin
        inv_n = '0;
        for (int i = 0; i < MAX_IMAGES; i++)
        begin
            ovl_act[i] = act_mask_reg[i] && (IW'(i) == idx ||
                         (act_s < img_end[i] && img_start[i] < act_e));
            ovl_inv[i] = act_mask_reg[i] &&
                         (range_start < img_end[i] && img_start[i] < range_end);
            inv_n = inv_n + SW'(ovl_inv[i]);
        end
    end

    assign owner_hit_c = act_mask_reg[scan_idx_reg] &&
                         pc_reg >= img_start[scan_idx_reg] &&
                         pc_reg < img_end[scan_idx_reg];

    assign stat.is_resolve  = is_res_reg;
    assign stat.scan_last   = (scan_idx_reg == IW'(MAX_IMAGES - 1));
    assign stat.owner_hit   = owner_hit_c;
    assign stat.search_done = (lo_reg >= hi_reg);

    // entry store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && opcode == OP_ADD && add_st == ST_OK)
        begin
            key_mem[slot[AW-1:0]] <= in_key;
            hnd_mem[slot[AW-1:0]] <= hnd_m;
        end
        if (cmd.rd || cmd.fin_rd)
        begin
            rd_key_reg <= key_mem[AW'(base_reg + AW'(cmd.rd ? mid : lo_reg))];
            rd_hnd_reg <= hnd_mem[AW'(base_reg + AW'(cmd.rd ? mid : lo_reg))];
        end
    end

    // image table payload
    always_ff @(posedge clk)
    begin
        if (cmd.load && opcode == OP_ADD && add_st == ST_OK && entry_last)
        begin
            img_start[pid_reg] <= pstart_reg;
            img_end[pid_reg]   <= pend_reg;
            img_base[pid_reg]  <= fill_reg[AW-1:0];
            img_count[pid_reg] <= pcount_reg + CW'(1);
        end
    end

    // search payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pc_reg     <= entry_pc;
            target_reg <= {entry_pc, entry_mode != 8'd0};
        end
        if (cmd.scan && owner_hit_c)
        begin
            base_reg <= img_base[scan_idx_reg];
            cnt_reg  <= img_count[scan_idx_reg];
            lo_reg   <= '0;
            hi_reg   <= img_count[scan_idx_reg];
        end
        else if (cmd.step)
        begin
            if (rd_key_reg < target_reg)
                lo_reg <= mid + CW'(1);
            else
                hi_reg <= mid;
        end
    end

    // control state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_mask_reg    <= '0;
            act_mask_reg    <= '0;
            fill_reg        <= '0;
            pcount_reg      <= '0;
            pvalid_reg      <= 1'b0;
            pid_reg         <= '0;
            pstart_reg      <= '0;
            pend_reg        <= '0;
            prev_key_reg    <= '0;
            scan_idx_reg    <= '0;
            is_res_reg      <= 1'b0;
            status_reg      <= '0;
            hit_reg         <= 1'b0;
            hit_handle_reg  <= '0;
            owner_found_reg <= 1'b0;
            owner_id_reg    <= '0;
            removed_reg     <= '0;
            act_flag_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                status_reg      <= ST_OK;
                hit_reg         <= 1'b0;
                hit_handle_reg  <= '0;
                owner_found_reg <= 1'b0;
                owner_id_reg    <= '0;
                removed_reg     <= '0;
                act_flag_reg    <= 1'b0;
                scan_idx_reg    <= '0;
                is_res_reg      <= (opcode == OP_RESOLVE);
                case (opcode)
                    OP_BEGIN:
                    begin
                        pvalid_reg <= 1'b0;
                        if (!id_ok)
                            status_reg <= ST_FULL;
                        else if (reg_mask_reg[idx])
                            status_reg <= ST_ALREADY;
                        else if (range_start >= range_end)
                            status_reg <= ST_EMPTY;
                        else
                        begin
                            pvalid_reg   <= 1'b1;
                            pid_reg      <= idx;
                            pstart_reg   <= range_start;
                            pend_reg     <= range_end;
                            pcount_reg   <= '0;
                            prev_key_reg <= '0;
                        end
                    end
                    OP_ADD:
                    begin
                        status_reg <= add_st;
                        if (add_st != ST_OK)
                            pvalid_reg <= 1'b0;
                        else
                        begin
                            prev_key_reg <= in_key;
                            if (entry_last)
                            begin
                                fill_reg     <= slot + CW'(1);
                                reg_mask_reg[pid_reg] <= 1'b1;
                                pvalid_reg   <= 1'b0;
                                pcount_reg   <= '0;
                            end
                            else
                                pcount_reg <= pcount_reg + CW'(1);
                        end
                    end
                    OP_ACTIVATE:
                    begin
                        if (!id_ok || !reg_mask_reg[idx])
                            status_reg <= ST_NOT_REG;
                        else
                        begin
                            act_mask_reg <= (act_mask_reg & ~ovl_act) |
                                            (MAX_IMAGES'(1) << idx);
                        end
                    end
                    OP_INVALIDATE:
                    begin
                        if (range_start < range_end)
                        begin
                            act_mask_reg <= act_mask_reg & ~ovl_inv;
                            removed_reg  <= 5'(inv_n);
                        end
                    end
                    OP_QUERY:
                        act_flag_reg <= id_ok && act_mask_reg[idx];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan)
            begin
                if (owner_hit_c)
                begin
                    owner_found_reg <= 1'b1;
                    owner_id_reg    <= 4'(scan_idx_reg);
                end
                else
                    scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            if (cmd.finish)
            begin
                if (lo_reg < cnt_reg && rd_key_reg == target_reg)
                begin
                    hit_reg        <= 1'b1;
                    hit_handle_reg <= 16'(rd_hnd_reg[HB-1:0]);
                end
            end
        end
    end

    assign status         = status_reg;
    assign hit            = hit_reg;
    assign hit_handle     = hit_handle_reg;
    assign owner_found    = owner_found_reg;
    assign owner_id       = owner_id_reg;
    assign removed_count  = removed_reg;
    assign is_active_flag = act_flag_reg;

endmodule

@@ hdl/odt_ctrl.sv @@
module odt_ctrl
    import odt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.is_resolve)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan = 1'b1;
                    if (stat.owner_hit)
                        state_next = S_SEARCH;
                    else if (stat.scan_last)
                        state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.step   = 1'b1;
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

@@ hdl/overlay_dispatch_table.sv @@
// Channel | Handshake              | Beat
// in      | in_valid / in_ready    | opcode, image_id, range_*, entry_*
// out     | out_valid / out_ready  | status, hit, hit_handle, owner_*, removed_count,
//         |                        | is_active_flag
// One item at a time. Most operations pass through accept, the scan state and result.
// Resolve instead scans images one by one (up to MAX_IMAGES tried), then, on an owner
// hit, runs a binary search on the entry-store read port, each step a read at mid and
// a narrowing of the window, and ends with a read at lo and a check of that entry.
// Reset clears masks, fill pointer and open registration; stores are not cleared.
// in_ready is held low until the result beat is taken.
module overlay_dispatch_table
    import odt_pkg::*;
#(
    parameter int MAX_IMAGES        = MAX_IMAGES_DEF,
    parameter int ENTRY_STORE_DEPTH = ENTRY_STORE_DEPTH_DEF,
    parameter int HANDLE_BITS       = HANDLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  image_id,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    input  logic [31:0] entry_pc,
    input  logic [7:0]  entry_mode,
    input  logic [15:0] entry_handle,
    input  logic        entry_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic        hit,
    output logic [15:0] hit_handle,
    output logic        owner_found,
    output logic [3:0]  owner_id,
    output logic [4:0]  removed_count,
    output logic        is_active_flag
);

    cmd_t  cmd;
    stat_t stat;

    odt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    odt_datapath #(
        .MAX_IMAGES        (MAX_IMAGES),
        .ENTRY_STORE_DEPTH (ENTRY_STORE_DEPTH),
        .HANDLE_BITS       (HANDLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .image_id       (image_id),
        .range_start    (range_start),
        .range_end      (range_end),
        .entry_pc       (entry_pc),
        .entry_mode     (entry_mode),
        .entry_handle   (entry_handle),
        .entry_last     (entry_last),
        .status         (status),
        .hit            (hit),
        .hit_handle     (hit_handle),
        .owner_found    (owner_found),
        .owner_id       (owner_id),
        .removed_count  (removed_count),
        .is_active_flag (is_active_flag)
    );

endmodule
